/* src/ptcs_pkg.sv */
`default_nettype none

package ptcs_pkg;

  localparam int unsigned InW   = 168;
  localparam int unsigned OutW  = 224;
  localparam int unsigned FuncW = 2;

  localparam logic [FuncW-1:0] FUNC_IRQ   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_START = 2'd1;
  localparam logic [FuncW-1:0] FUNC_STOP  = 2'd2;

  localparam logic [31:0] FREQ_RESET     = 32'd100000000;
  localparam logic [63:0] PARKED_COMPARE = 64'h8000_0000_0000_0000;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_SEL  = 9'b000001000,
    S_PREP = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_ADD  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

/* src/periodic_tick_compare_scheduler.sv */
// Periodic tick compare scheduler.
// Input items arrive on the s_axis channel: tuser carries the function code
// (interrupt, start, stop) and tdata the tick counter value and the start
// arguments. Each interrupt, start or stop item yields one result beat on the
// m_axis channel with the new compare value, the delivered event count and
// the four statistics counters. Items with the unused code are taken and
// dropped. The counter frequency is to be written on the cfg channel only
// while idle; the block itself does not enforce this. One item is worked on
// at a time and s_axis_tready is low meanwhile. All divisions run through
// one restoring divider that retires one quotient bit per cycle; the tick
// conversions share one 32 x 32 multiplier. A stop item goes from prepare to
// done; an interrupt item runs the 64 divider steps (skipped with no period
// set) and finish; a start item runs the multiply-accumulate and select
// states, the divider (skipped for a zero period), finish and add. The next
// item is taken in the cycle after a result is loaded.
// A finished result sits in an output register; the next item is accepted
// while it waits, and the block holds its following result until the
// receiver takes the earlier one.
// Reset stops the timer, clears the reference time, the adjustment and the
// statistics, and sets the counter frequency to 100 MHz.
`default_nettype none

module periodic_tick_compare_scheduler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tick_now, events_active, period_given, period_sec, period_frac,
  // first_given, first_sec, first_frac, zero fill
  input  wire logic [ptcs_pkg::InW-1:0]   s_axis_tdata_i,
  // func
  input  wire logic [ptcs_pkg::FuncW-1:0] s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // compare_value, event_count, edges_total, excess_total, missed_total,
  // adjusted_total
  output logic [ptcs_pkg::OutW-1:0]       m_axis_tdata_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [31:0]                cfg_data_i
);

  import ptcs_pkg::*;

  state_e state_q, state_d;

  logic [31:0] freq_q;
  logic [63:0] period_q, ref_q, adj_q;
  logic [31:0] late_q, empty_q, missed_q, adjcnt_q;

  logic [FuncW-1:0] func_q;
  logic [63:0] now_q;
  logic        active_q, pgiven_q, fgiven_q;
  logic [16:0] psec_q, fsec_q;
  logic [31:0] pfrac_q, ffrac_q;

  logic [1:0]  mstep_q;
  logic [63:0] prod_q, acc_q, per_new_q, first_q;
  logic [63:0] x_q, quo_q, rem_q, divisor_q, cmp_q;
  logic [31:0] ev_q;
  logic [5:0]  dcnt_q;

  logic        m_valid_q;
  logic [OutW-1:0] m_data_q;

  logic        in_fire, out_load;
  logic [31:0] mul_b;
  logic [65:0] trial;
  logic        borrow;
  logic [63:0] d_irq, r_fin, base;
  logic [31:0] n_lo;
  logic        n_nz;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign out_load        = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    case (mstep_q)
      2'd0:    mul_b = pfrac_q;
      2'd1:    mul_b = {15'd0, psec_q};
      2'd2:    mul_b = ffrac_q;
      default: mul_b = {15'd0, fsec_q};
    endcase
  end

  assign trial  = {1'b0, rem_q, quo_q[63]} - {2'b00, divisor_q};
  assign borrow = trial[65];
  assign d_irq  = now_q - ref_q;
  assign r_fin  = rem_q;
  assign base   = x_q - rem_q;
  assign n_lo   = quo_q[31:0];
  assign n_nz   = (quo_q != 64'd0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == FUNC_START) begin
            state_d = S_MUL;
          end else if (s_axis_tuser_i == FUNC_IRQ || s_axis_tuser_i == FUNC_STOP) begin
            state_d = S_PREP;
          end
        end
      end
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = (mstep_q == 2'd3) ? S_SEL : S_MUL;
      S_SEL:  state_d = S_PREP;
      S_PREP: begin
        if (func_q == FUNC_STOP) begin
          state_d = S_DONE;
        end else if (func_q == FUNC_IRQ) begin
          state_d = (period_q != 64'd0) ? S_DIV : S_FIN;
        end else begin
          state_d = (per_new_q != 64'd0) ? S_DIV : S_FIN;
        end
      end
      S_DIV:  state_d = (dcnt_q == 6'd63) ? S_FIN : S_DIV;
      S_FIN:  state_d = (func_q == FUNC_START) ? S_ADD : S_DONE;
      S_ADD:  state_d = S_DONE;
      S_DONE: state_d = out_load ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      mstep_q   <= 2'd0;
      dcnt_q    <= 6'd0;
      freq_q    <= FREQ_RESET;
      period_q  <= 64'd0;
      ref_q     <= 64'd0;
      adj_q     <= 64'd0;
      late_q    <= 32'd0;
      empty_q   <= 32'd0;
      missed_q  <= 32'd0;
      adjcnt_q  <= 32'd0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        freq_q <= cfg_data_i;
      end
      if (in_fire) begin
        mstep_q <= 2'd0;
      end else if (state_q == S_ACC) begin
        mstep_q <= mstep_q + 2'd1;
      end
      if (state_q == S_PREP) begin
        dcnt_q <= 6'd0;
      end else if (state_q == S_DIV) begin
        dcnt_q <= dcnt_q + 6'd1;
      end
      if (state_q == S_PREP && func_q == FUNC_STOP) begin
        period_q <= 64'd0;
      end
      if (state_q == S_FIN) begin
        if (func_q == FUNC_START) begin
          period_q <= per_new_q;
          adj_q    <= 64'd0;
          ref_q    <= base;
        end else begin
          ref_q <= now_q - r_fin;
          if (n_nz) begin
            missed_q <= missed_q + n_lo - 32'd1;
            if (adj_q != 64'd0) begin
              adjcnt_q <= adjcnt_q + n_lo;
            end
            if (r_fin > {3'd0, period_q[63:3]}) begin
              if (adj_q == 64'd0) begin
                late_q <= late_q + 32'd1;
              end
              adj_q <= {4'd0, period_q[63:4]};
            end else begin
              adj_q <= 64'd0;
            end
          end else begin
            adj_q   <= 64'd0;
            empty_q <= empty_q + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= s_axis_tuser_i;
      now_q    <= s_axis_tdata_i[63:0];
      active_q <= s_axis_tdata_i[64];
      pgiven_q <= s_axis_tdata_i[65];
      psec_q   <= s_axis_tdata_i[82:66];
      pfrac_q  <= s_axis_tdata_i[114:83];
      fgiven_q <= s_axis_tdata_i[115];
      fsec_q   <= s_axis_tdata_i[132:116];
      ffrac_q  <= s_axis_tdata_i[164:133];
    end
    case (state_q)
      S_MUL: begin
        prod_q <= {32'd0, freq_q} * {32'd0, mul_b};
      end
      S_ACC: begin
        case (mstep_q)
          2'd0:    acc_q     <= {32'd0, prod_q[63:32]};
          2'd1:    per_new_q <= acc_q + prod_q;
          2'd2:    acc_q     <= {32'd0, prod_q[63:32]};
          default: first_q   <= acc_q + prod_q;
        endcase
      end
      S_SEL: begin
        per_new_q <= pgiven_q ? per_new_q : 64'd0;
        first_q   <= fgiven_q ? first_q : (pgiven_q ? per_new_q : 64'd0);
      end
      S_PREP: begin
        rem_q <= 64'd0;
        ev_q  <= 32'd0;
        if (func_q == FUNC_STOP) begin
          cmp_q <= PARKED_COMPARE;
        end else if (func_q == FUNC_IRQ) begin
          cmp_q     <= now_q + period_q;
          divisor_q <= period_q;
          if (period_q != 64'd0) begin
            quo_q <= d_irq;
          end else begin
            quo_q <= 64'd1;
            rem_q <= d_irq;
          end
        end else begin
          divisor_q <= per_new_q;
          if (per_new_q != 64'd0) begin
            x_q   <= now_q + per_new_q - 64'd1;
            quo_q <= now_q + per_new_q - 64'd1;
          end else begin
            x_q <= now_q;
          end
        end
      end
      S_DIV: begin
        quo_q <= {quo_q[62:0], !borrow};
        rem_q <= borrow ? {rem_q[62:0], quo_q[63]} : trial[63:0];
      end
      S_FIN: begin
        if (func_q == FUNC_START) begin
          cmp_q <= base;
        end else begin
          cmp_q <= (period_q != 64'd0) ? (cmp_q - adj_q) : PARKED_COMPARE;
          ev_q  <= active_q ? n_lo : 32'd0;
        end
      end
      S_ADD: begin
        cmp_q <= cmp_q + first_q;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_data_q <= {adjcnt_q, missed_q, empty_q, late_q, ev_q, cmp_q};
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < divisor_q)
    else $error("divider remainder reached the divisor");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && dcnt_q == 6'd63) |=> state_q == S_FIN)
    else $error("divider did not finish after 64 steps");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_stop_clears_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && func_q == FUNC_STOP) |-> period_q == 64'd0)
    else $error("stop left the period running");

endmodule

`default_nettype wire

/* sim/ptcs_tb_pkg.sv */
`timescale 1ns / 1ps

package ptcs_tb_pkg;

  localparam logic [ptcs_pkg::FuncW-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  fill;
    logic [31:0] first_frac;
    logic [16:0] first_sec;
    logic        first_given;
    logic [31:0] period_frac;
    logic [16:0] period_sec;
    logic        period_given;
    logic        events_active;
    logic [63:0] tick_now;
  } item_t;

  typedef struct packed {
    logic [31:0] adjusted_total;
    logic [31:0] missed_total;
    logic [31:0] excess_total;
    logic [31:0] edges_total;
    logic [31:0] event_count;
    logic [63:0] compare_value;
  } result_t;

endpackage

/* sim/ptcs_result_checker.sv */
`timescale 1ns / 1ps

module ptcs_result_checker
  import ptcs_pkg::*;
  import ptcs_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  item_t            in_item_i,
  input  logic [FuncW-1:0] in_func_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  result_t          out_result_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [31:0]      cfg_data_i,
  output int               mismatches_o,
  output int               pending_o
);

  logic [31:0] frequency;
  logic [63:0] period_ticks;
  logic [63:0] ref_time;
  logic [63:0] adjust;
  logic [31:0] late_edges;
  logic [31:0] empty_irqs;
  logic [31:0] missed_periods;
  logic [31:0] adjusted_periods;
  result_t     expected_results[$];
  int          mismatches = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[ptcs_result_checker] %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got %h, expected %h", name, got, want));
    end
  endtask

  function automatic logic [63:0] seconds_to_ticks(input logic [16:0] sec,
                                                   input logic [31:0] frac);
    logic [63:0] f;
    f = {32'd0, frequency};
    return ((f * {32'd0, frac}) >> 32) + f * {47'd0, sec};
  endfunction

  function automatic bit predict(input logic [FuncW-1:0] func, input item_t it,
                                 output result_t res);
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] base;
    logic [63:0] first;
    res = '0;
    case (func)
      FUNC_IRQ: begin
        p = period_ticks;
        a = adjust;
        res.compare_value = (p != 64'd0) ? it.tick_now + p - a : PARKED_COMPARE;
        d = it.tick_now - ref_time;
        if (p != 64'd0) begin
          n = d / p;
          r = d % p;
        end else begin
          n = 64'd1;
          r = d;
        end
        ref_time = ref_time + n * p;
        if (n != 64'd0) begin
          missed_periods = missed_periods + n[31:0] - 32'd1;
          if (a != 64'd0) begin
            adjusted_periods = adjusted_periods + n[31:0];
          end
          if (r > (p >> 3)) begin
            if (a == 64'd0) begin
              late_edges = late_edges + 32'd1;
            end
            adjust = p >> 4;
          end else begin
            adjust = 64'd0;
          end
        end else begin
          adjust = 64'd0;
          empty_irqs = empty_irqs + 32'd1;
        end
        res.event_count = it.events_active ? n[31:0] : 32'd0;
      end
      FUNC_START: begin
        p = it.period_given ? seconds_to_ticks(it.period_sec, it.period_frac) : 64'd0;
        first = it.first_given ? seconds_to_ticks(it.first_sec, it.first_frac) : p;
        base = it.tick_now;
        if (p != 64'd0) begin
          base = ((base + p - 64'd1) / p) * p;
        end
        period_ticks = p;
        adjust = 64'd0;
        ref_time = base;
        res.compare_value = base + first;
      end
      FUNC_STOP: begin
        period_ticks = 64'd0;
        res.compare_value = PARKED_COMPARE;
      end
      default: begin
        return 1'b0;
      end
    endcase
    res.edges_total    = late_edges;
    res.excess_total   = empty_irqs;
    res.missed_total   = missed_periods;
    res.adjusted_total = adjusted_periods;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    bit      produces;
    if (!rst_ni) begin
      frequency        = FREQ_RESET;
      period_ticks     = 64'd0;
      ref_time         = 64'd0;
      adjust           = 64'd0;
      late_edges       = 32'd0;
      empty_irqs       = 32'd0;
      missed_periods   = 32'd0;
      adjusted_periods = 32'd0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding, compare_value %h",
                                    out_result_i.compare_value));
        end else begin
          want = expected_results.pop_front();
          compare_field("compare_value", out_result_i.compare_value, want.compare_value);
          compare_field("event_count", out_result_i.event_count, want.event_count);
          compare_field("edges_total", out_result_i.edges_total, want.edges_total);
          compare_field("excess_total", out_result_i.excess_total, want.excess_total);
          compare_field("missed_total", out_result_i.missed_total, want.missed_total);
          compare_field("adjusted_total", out_result_i.adjusted_total,
                        want.adjusted_total);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        frequency = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        produces = predict(in_func_i, in_item_i, want);
        if (produces) begin
          expected_results.push_back(want);
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

/* sim/periodic_tick_compare_scheduler_tb.sv */
`timescale 1ns / 1ps

module periodic_tick_compare_scheduler_tb;
  import ptcs_pkg::*;
  import ptcs_tb_pkg::*;

  localparam int          ResetCycles   = 12;
  localparam int          SettleCycles  = 100;
  localparam int          HoldCycles    = 400;
  localparam int          WatchdogLimit = 3000;
  localparam int          HoldItem      = 200;
  localparam int          PauseItem     = 330;
  localparam int          SteadyFirst   = 420;
  localparam int          SteadyLast    = 520;
  localparam logic [31:0] Frac10kTicks  = 32'd429496;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  item_t            s_axis_tdata_i  = '0;
  logic [FuncW-1:0] s_axis_tuser_i  = FUNC_IRQ;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  result_t          m_axis_tdata_o;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [31:0]      cfg_data_i      = '0;

  int          mismatches;
  int          pending;
  int          idle_cycles   = 0;
  int          items_offered = 0;
  logic [31:0] frequency_now = FREQ_RESET;
  bit          hold_off      = 1'b0;
  bit          steady        = 1'b0;

  periodic_tick_compare_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  ptcs_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_i   (s_axis_tready_o),
    .in_item_i    (s_axis_tdata_i),
    .in_func_i    (s_axis_tuser_i),
    .out_valid_i  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_i (m_axis_tdata_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("[periodic_tick_compare_scheduler] ERROR");
    $finish;
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  function automatic logic [63:0] below(input logic [63:0] lim);
    return (lim == 64'd0) ? 64'd0 : {$urandom, $urandom} % lim;
  endfunction

  function automatic logic [63:0] tick_estimate(input logic [16:0] sec,
                                                input logic [31:0] frac);
    return (({32'd0, frequency_now} * {32'd0, frac}) >> 32) +
           {32'd0, frequency_now} * {47'd0, sec};
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.fill          = '0;
    it.tick_now      = {$urandom, $urandom};
    it.events_active = 1'($urandom_range(1));
    it.period_given  = 1'($urandom_range(1));
    it.period_sec    = 17'($urandom_range(86400));
    it.period_frac   = $urandom;
    it.first_given   = 1'($urandom_range(1));
    it.first_sec     = 17'($urandom_range(86400));
    it.first_frac    = $urandom;
    return it;
  endfunction

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic offer(input logic [FuncW-1:0] func, input item_t it);
    if (items_offered == HoldItem) begin
      hold_off = 1'b1;
    end
    if (items_offered == PauseItem) begin
      wait_for_results();
    end
    steady = (items_offered >= SteadyFirst) && (items_offered < SteadyLast);
    while (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= it;
    s_axis_tuser_i  <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_offered++;
  endtask

  task automatic offer_at(input logic [FuncW-1:0] func, input logic [63:0] now);
    item_t it;
    it = random_item();
    it.tick_now = now;
    offer(func, it);
  endtask

  task automatic offer_start(input logic [63:0] now, input logic pg, input logic [16:0] ps,
                             input logic [31:0] pf, input logic fg, input logic [16:0] fs,
                             input logic [31:0] ff);
    item_t it;
    it = random_item();
    it.tick_now     = now;
    it.period_given = pg;
    it.period_sec   = ps;
    it.period_frac  = pf;
    it.first_given  = fg;
    it.first_sec    = fs;
    it.first_frac   = ff;
    offer(FUNC_START, it);
  endtask

  task automatic write_frequency(input logic [31:0] f);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    frequency_now = f;
  endtask

  task automatic run_directed();
    item_t it;
    offer_at(FUNC_STOP, 64'd0);
    offer_at(FUNC_IRQ, 64'd5);
    offer_at(FUNC_IRQ, '1);
    offer_start(64'd123, 1'b0, 17'd0, 32'd0, 1'b0, 17'd0, 32'd0);
    offer_at(FUNC_IRQ, 64'd200);
    offer_start(64'd1000, 1'b0, 17'd0, 32'd0, 1'b1, 17'd0, 32'h8000_0000);
    offer_at(FUNC_IRQ, 64'd50_001_000);
    offer_start(64'd0, 1'b1, 17'd0, Frac10kTicks, 1'b0, 17'd0, 32'd0);
    it = random_item();
    it.tick_now      = 64'd9999;
    it.events_active = 1'b1;
    offer(FUNC_IRQ, it);
    it.tick_now      = 64'd21498;
    it.events_active = 1'b0;
    offer(FUNC_IRQ, it);
    offer_at(FUNC_IRQ, 64'd30007);
    it.tick_now      = 64'd80012;
    it.events_active = 1'b1;
    offer(FUNC_IRQ, it);
    offer_at(FUNC_IRQ, 64'd80112);
    offer_at(FUNC_UNUSED, '1);
    offer_start('1, 1'b1, 17'd86400, '1, 1'b1, 17'd86400, '1);
    offer_start(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 17'd0, Frac10kTicks, 1'b1, 17'd1, 32'd0);
    offer_at(FUNC_IRQ, 64'd9999);
    offer_start(64'd777, 1'b1, 17'd1, 32'd0, 1'b1, 17'd0, 32'd0);
    offer_at(FUNC_IRQ, 64'd100_000_777);
    offer_at(FUNC_STOP, 64'd100_000_800);
    offer_at(FUNC_IRQ, 64'd100_000_900);
    offer_at(FUNC_STOP, '1);
  endtask

  task automatic run_random(input int budget);
    int          stop_at;
    int          pick;
    item_t       it;
    logic [63:0] now;
    logic [63:0] period;
    logic [63:0] first;
    logic [63:0] step;
    stop_at = items_offered + budget;
    now = {$urandom, $urandom};
    while (items_offered < stop_at) begin
      it = random_item();
      it.period_given = ($urandom_range(9) != 0);
      it.period_sec   = ($urandom_range(9) == 0) ? 17'($urandom_range(86400))
                                                  : 17'($urandom_range(3));
      it.first_sec    = ($urandom_range(9) == 0) ? 17'($urandom_range(86400))
                                                  : 17'($urandom_range(3));
      if ($urandom_range(4) != 0) begin
        now = now + below(64'd1000);
      end else begin
        now = {$urandom, $urandom};
      end
      it.tick_now = now;
      offer(FUNC_START, it);
      period = it.period_given ? tick_estimate(it.period_sec, it.period_frac) : 64'd0;
      first  = it.first_given ? tick_estimate(it.first_sec, it.first_frac) : period;
      now    = now + first - period;
      repeat ($urandom_range(25, 3)) begin
        pick = $urandom_range(99);
        if (period == 64'd0) begin
          step = below(64'd1000);
        end else if (pick < 50) begin
          step = period + below((period >> 4) + 64'd1);
        end else if (pick < 65) begin
          step = period + (period >> 3) + 64'd1 + below((period >> 1) + 64'd1);
        end else if (pick < 77) begin
          step = period * $urandom_range(6, 2) + below((period >> 4) + 64'd1);
        end else if (pick < 87) begin
          step = below((period >> 1) + 64'd1);
        end else if (pick < 93) begin
          step = {$urandom, $urandom} >> $urandom_range(63);
        end else begin
          step = {$urandom, $urandom} - now;
        end
        now = now + step;
        offer_at(FUNC_IRQ, now);
      end
      pick = $urandom_range(9);
      if (pick < 3) begin
        offer_at(FUNC_STOP, now);
        if ($urandom_range(1) != 0) begin
          offer_at(FUNC_IRQ, now + below(64'd1000));
        end
      end else if (pick == 3) begin
        offer_at(FUNC_UNUSED, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    write_frequency(32'hFFFF_FFFF);
    run_random(120);
    write_frequency(32'd1);
    run_random(100);
    write_frequency(32'd0);
    run_random(30);
    write_frequency($urandom_range(32'hFFFF_FFFE, 2));
    run_random(200);
    write_frequency(FREQ_RESET);
    run_random(150);
    wait_for_results();
    if (mismatches == 0) begin
      $display("[periodic_tick_compare_scheduler] OK");
    end else begin
      $display("[periodic_tick_compare_scheduler] ERROR");
    end
    $finish;
  end

endmodule
